/* hw/rtl/slpg_pkg.sv */
// Shared types, constants and tables of the status LED pattern generator.
package slpg_pkg;

  typedef enum logic [1:0] {
    HealthOk       = 2'd0,
    HealthWarn     = 2'd1,
    HealthError    = 2'd2,
    HealthUpdating = 2'd3
  } health_e;

  typedef enum logic [1:0] {
    ModeClassic   = 2'd0,
    ModeFlow      = 2'd1,
    ModeHeartbeat = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    AlertNormal  = 2'd0,
    AlertWarning = 2'd1,
    AlertError   = 2'd2
  } alert_e;

  typedef enum logic [2:0] {
    RegPatternMode    = 3'd0,
    RegGrbOrder       = 3'd1,
    RegPeakBrightness = 3'd2,
    RegOverrideEnable = 3'd3,
    RegOverrideRgb    = 3'd4,
    RegOverridePeriod = 3'd5
  } cfg_idx_e;

  localparam int unsigned RampPeriodMsDefault = 3000;
  localparam int unsigned ApexClassic = 500;
  localparam int unsigned ApexFlow = 950;
  localparam int unsigned ApexScale = 1000;
  localparam int signed PowerDeadBand = 50;

  localparam int unsigned HbMinuteMs = 60000;
  localparam int unsigned HbBpmNormal = 35;
  localparam int unsigned HbBpmWarning = 70;
  localparam int unsigned HbBpmError = 100;
  localparam int unsigned HbDenW = 11;
  localparam logic [HbDenW-1:0] HbPeriodNormal = HbDenW'(HbMinuteMs / HbBpmNormal);
  localparam logic [HbDenW-1:0] HbPeriodWarning = HbDenW'(HbMinuteMs / HbBpmWarning);
  localparam logic [HbDenW-1:0] HbPeriodError = HbDenW'(HbMinuteMs / HbBpmError);
  localparam int unsigned HbScale = 1000;
  localparam int unsigned HbNumW = 21;

  localparam int unsigned DivStep = 4;
  localparam int unsigned NowW = 32;
  localparam int unsigned HalfW = 15;
  localparam int unsigned LerpNumW = 19;
  localparam int unsigned LerpDenW = 9;
  localparam int unsigned ScaleNumW = 18;
  localparam int unsigned ScaleDenW = 10;

  typedef struct packed {
    logic [9:0] x0;
    logic [8:0] span;
    logic [9:0] y0;
    logic [9:0] dy_mag;
    logic       dy_neg;
  } hb_seg_t;

  localparam int unsigned HbSegCount = 7;
  localparam hb_seg_t HbSeg [HbSegCount] = '{
    '{10'd0,   9'd100, 10'd150, 10'd50,  1'b1},
    '{10'd100, 9'd100, 10'd100, 10'd50,  1'b1},
    '{10'd200, 9'd50,  10'd50,  10'd750, 1'b0},
    '{10'd250, 9'd50,  10'd800, 10'd700, 1'b1},
    '{10'd300, 9'd100, 10'd100, 10'd450, 1'b0},
    '{10'd400, 9'd150, 10'd550, 10'd300, 1'b1},
    '{10'd550, 9'd450, 10'd250, 10'd100, 1'b1}
  };

  typedef struct packed {
    logic              ovr;
    health_e           health;
    logic              pwr_neg;
    logic              pwr_pos;
    logic [HbDenW-1:0] hb_den;
  } side_a_t;

  typedef struct packed {
    logic    ovr;
    logic    blink;
    health_e health;
    logic    hb;
    logic    negate;
    logic    rising;
  } side_b_t;

  typedef struct packed {
    logic       ovr;
    logic       blink;
    health_e    health;
    logic       hb;
    logic [7:0] ramp_level;
    logic [9:0] y0;
    logic [9:0] dy_mag;
    logic       dy_neg;
  } side_c_t;

  typedef struct packed {
    logic       ovr;
    logic       blink;
    health_e    health;
    logic       hb;
    logic [7:0] ramp_level;
  } side_d_t;

  typedef struct packed {
    logic       ovr;
    logic       blink;
    health_e    health;
    logic [7:0] level;
  } pix_t;

endpackage

/* hw/rtl/status_led_pattern_generator.sv */
// Top level of the status LED pattern generator pipeline.
// A transaction starts when start is high while busy is low; busy stays low, so
// a new timestamp with its health, alert and power may be given in every cycle.
// Each transaction gives exactly one result: done_o is high for one cycle with
// pixel_word_o and level_o, and the receiver must take it in that cycle.
// Throughput is one transaction a cycle. The pipeline chains four pipelined
// divider stages: the timestamp modulo stage, the ramp and heartbeat phase
// stage, the heartbeat interpolation stage and the brightness scaling stage,
// each resolving four quotient bits a stage. Configuration is written through
// cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must write it only while no
// transaction is in flight, which the block does not enforce. Writes to unused
// indexes are ignored. Reset clears all valid bits and loads the register
// defaults: classic ramp, RGB order, full peak brightness and the blink
// override off.
module status_led_pattern_generator #(
  parameter int unsigned RAMP_PERIOD_MS = slpg_pkg::RampPeriodMsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        now_ms_i,
  input  logic [1:0]         health_i,
  input  logic [1:0]         alert_level_i,
  input  logic signed [31:0] power_watts_i,
  output logic               done_o,
  output logic [23:0]        pixel_word_o,
  output logic [7:0]         level_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i
);

  import slpg_pkg::*;

  localparam int unsigned RampW = $clog2(RAMP_PERIOD_MS + 1);
  localparam int unsigned RampNumW = RampW + 8;
  localparam int unsigned NumBW = (RampNumW > HbNumW) ? RampNumW : HbNumW;
  localparam logic [RampW-1:0] Period = RampW'(RAMP_PERIOD_MS);
  localparam logic [RampW-1:0] MidClassic = RampW'(ApexClassic * RAMP_PERIOD_MS / ApexScale);
  localparam logic [RampW-1:0] MidFlow = RampW'(ApexFlow * RAMP_PERIOD_MS / ApexScale);
  localparam int unsigned StagesA = (NowW + DivStep - 1) / DivStep;
  localparam int unsigned StagesB = (NumBW + DivStep - 1) / DivStep;
  localparam int unsigned StagesC = (LerpNumW + DivStep - 1) / DivStep;
  localparam int unsigned StagesD = (ScaleNumW + DivStep - 1) / DivStep;
  localparam int unsigned Latency = StagesA + StagesB + StagesC + StagesD + 4;

  // Configuration registers.
  mode_e       mode_q;
  logic        grb_q;
  logic [7:0]  peak_q;
  logic        ovr_en_q;
  logic [23:0] ovr_rgb_q;
  logic [15:0] ovr_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeClassic;
      grb_q        <= 1'b0;
      peak_q       <= 8'hFF;
      ovr_en_q     <= 1'b0;
      ovr_rgb_q    <= '0;
      ovr_period_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        RegPatternMode:    mode_q       <= mode_e'(cfg_wdata_i[1:0]);
        RegGrbOrder:       grb_q        <= cfg_wdata_i[0];
        RegPeakBrightness: peak_q       <= cfg_wdata_i[7:0];
        RegOverrideEnable: ovr_en_q     <= cfg_wdata_i[0];
        RegOverrideRgb:    ovr_rgb_q    <= cfg_wdata_i;
        RegOverridePeriod: ovr_period_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Input: divisors and sideband for the timestamp dividers.
  logic             accept;
  logic [HalfW-1:0] half;
  side_a_t          side_a_in, side_a_out;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign half   = (ovr_period_q[15:1] == '0) ? HalfW'(1) : ovr_period_q[15:1];

  always_comb begin
    side_a_in.ovr     = ovr_en_q && (ovr_period_q != '0);
    side_a_in.health  = health_e'(health_i);
    side_a_in.pwr_neg = power_watts_i < -PowerDeadBand;
    side_a_in.pwr_pos = power_watts_i > PowerDeadBand;
    unique case (alert_level_i)
      AlertWarning: side_a_in.hb_den = HbPeriodWarning;
      AlertError:   side_a_in.hb_den = HbPeriodError;
      default:      side_a_in.hb_den = HbPeriodNormal;
    endcase
  end

  logic              valid_a;
  logic [NowW-1:0]   quo_half_a;
  logic [RampW-1:0]  rem_ramp_a;
  logic [HbDenW-1:0] rem_hb_a;

  slpg_div #(.NumW(NowW), .DenW(HalfW), .StepBits(DivStep), .side_t(side_a_t)) u_div_half (
    .clk_i, .rst_ni, .valid_i(accept), .num_i(now_ms_i), .den_i(half),
    .side_i(side_a_in), .valid_o(valid_a), .quo_o(quo_half_a), .rem_o(), .side_o(side_a_out)
  );

  slpg_div #(.NumW(NowW), .DenW(RampW), .StepBits(DivStep)) u_div_ramp_mod (
    .clk_i, .rst_ni, .valid_i(accept), .num_i(now_ms_i), .den_i(Period),
    .side_i(1'b0), .valid_o(), .quo_o(), .rem_o(rem_ramp_a), .side_o()
  );

  slpg_div #(.NumW(NowW), .DenW(HbDenW), .StepBits(DivStep)) u_div_hb_mod (
    .clk_i, .rst_ni, .valid_i(accept), .num_i(now_ms_i), .den_i(side_a_in.hb_den),
    .side_i(1'b0), .valid_o(), .quo_o(), .rem_o(rem_hb_a), .side_o()
  );

  // Stage B preparation: ramp slope operands and heartbeat phase numerator.
  logic              valid_b_q;
  side_b_t           side_b_q, side_b_d;
  logic [NumBW-1:0]  ramp_num_q, ramp_num_d;
  logic [RampW-1:0]  ramp_den_q, ramp_den_d;
  logic [NumBW-1:0]  hb_num_q, hb_num_d;
  logic [HbDenW-1:0] hb_den_q;
  logic [RampW-1:0]  mid, ramp_x;
  logic              use_flow;

  always_comb begin
    use_flow = (mode_q == ModeFlow) && (side_a_out.pwr_neg || side_a_out.pwr_pos);
    mid = use_flow ? MidFlow : MidClassic;
    side_b_d.ovr    = side_a_out.ovr;
    side_b_d.blink  = quo_half_a[0];
    side_b_d.health = side_a_out.health;
    side_b_d.hb     = mode_q == ModeHeartbeat;
    side_b_d.negate = (mode_q == ModeFlow) && side_a_out.pwr_neg;
    side_b_d.rising = rem_ramp_a < mid;
    ramp_x     = side_b_d.rising ? rem_ramp_a : rem_ramp_a - mid;
    ramp_den_d = side_b_d.rising ? mid : Period - mid;
    ramp_num_d = NumBW'(RampNumW'(ramp_x) * RampNumW'(peak_q));
    hb_num_d   = NumBW'(HbNumW'(rem_hb_a) * HbNumW'(HbScale));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else begin
      valid_b_q <= valid_a;
    end
  end

  always_ff @(posedge clk_i) begin
    side_b_q   <= side_b_d;
    ramp_num_q <= ramp_num_d;
    ramp_den_q <= ramp_den_d;
    hb_num_q   <= hb_num_d;
    hb_den_q   <= side_a_out.hb_den;
  end

  logic             valid_b_out;
  side_b_t          side_b_out;
  logic [NumBW-1:0] quo_ramp_b, quo_pct_b;

  slpg_div #(.NumW(NumBW), .DenW(RampW), .StepBits(DivStep), .side_t(side_b_t)) u_div_ramp (
    .clk_i, .rst_ni, .valid_i(valid_b_q), .num_i(ramp_num_q), .den_i(ramp_den_q),
    .side_i(side_b_q), .valid_o(valid_b_out), .quo_o(quo_ramp_b), .rem_o(), .side_o(side_b_out)
  );

  slpg_div #(.NumW(NumBW), .DenW(HbDenW), .StepBits(DivStep)) u_div_phase (
    .clk_i, .rst_ni, .valid_i(valid_b_q), .num_i(hb_num_q), .den_i(hb_den_q),
    .side_i(1'b0), .valid_o(), .quo_o(quo_pct_b), .rem_o(), .side_o()
  );

  // Stage C preparation: ramp level and heartbeat segment interpolation.
  logic                valid_c_q;
  side_c_t             side_c_q, side_c_d;
  logic [LerpNumW-1:0] lerp_num_q, lerp_num_d;
  logic [LerpDenW-1:0] lerp_den_q;
  logic [7:0]          ramp_b;
  logic [9:0]          pct;
  logic [2:0]          seg_idx;
  logic [8:0]          dx;

  always_comb begin
    ramp_b = side_b_out.rising ? quo_ramp_b[7:0] : peak_q - quo_ramp_b[7:0];
    pct = quo_pct_b[9:0];
    seg_idx = '0;
    for (int unsigned i = 1; i < HbSegCount; i++) begin
      if (pct >= HbSeg[i].x0) begin
        seg_idx = 3'(i);
      end
    end
    dx = 9'(pct - HbSeg[seg_idx].x0);
    side_c_d.ovr        = side_b_out.ovr;
    side_c_d.blink      = side_b_out.blink;
    side_c_d.health     = side_b_out.health;
    side_c_d.hb         = side_b_out.hb;
    side_c_d.ramp_level = side_b_out.negate ? peak_q - ramp_b : ramp_b;
    side_c_d.y0         = HbSeg[seg_idx].y0;
    side_c_d.dy_mag     = HbSeg[seg_idx].dy_mag;
    side_c_d.dy_neg     = HbSeg[seg_idx].dy_neg;
    lerp_num_d = LerpNumW'(dx) * LerpNumW'(HbSeg[seg_idx].dy_mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else begin
      valid_c_q <= valid_b_out;
    end
  end

  always_ff @(posedge clk_i) begin
    side_c_q   <= side_c_d;
    lerp_num_q <= lerp_num_d;
    lerp_den_q <= HbSeg[seg_idx].span;
  end

  logic                valid_c_out;
  side_c_t             side_c_out;
  logic [LerpNumW-1:0] quo_c;

  slpg_div #(.NumW(LerpNumW), .DenW(LerpDenW), .StepBits(DivStep), .side_t(side_c_t)) u_div_lerp (
    .clk_i, .rst_ni, .valid_i(valid_c_q), .num_i(lerp_num_q), .den_i(lerp_den_q),
    .side_i(side_c_q), .valid_o(valid_c_out), .quo_o(quo_c), .rem_o(), .side_o(side_c_out)
  );

  // Stage D preparation: clamp the curve value and scale it by the peak.
  logic                 valid_d_q;
  side_d_t              side_d_q;
  logic [ScaleNumW-1:0] scale_num_q, scale_num_d;
  logic signed [11:0]   curve;
  logic [9:0]           curve_mag;

  always_comb begin
    curve = side_c_out.dy_neg
          ? $signed({2'b00, side_c_out.y0}) - $signed({2'b00, quo_c[9:0]})
          : $signed({2'b00, side_c_out.y0}) + $signed({2'b00, quo_c[9:0]});
    curve_mag = curve[11] ? '0 : curve[9:0];
    scale_num_d = ScaleNumW'(curve_mag) * ScaleNumW'(peak_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_d_q <= 1'b0;
    end else begin
      valid_d_q <= valid_c_out;
    end
  end

  always_ff @(posedge clk_i) begin
    side_d_q.ovr        <= side_c_out.ovr;
    side_d_q.blink      <= side_c_out.blink;
    side_d_q.health     <= side_c_out.health;
    side_d_q.hb         <= side_c_out.hb;
    side_d_q.ramp_level <= side_c_out.ramp_level;
    scale_num_q         <= scale_num_d;
  end

  logic                 valid_d_out;
  side_d_t              side_d_out;
  logic [ScaleNumW-1:0] quo_d;

  slpg_div #(.NumW(ScaleNumW), .DenW(ScaleDenW), .StepBits(DivStep), .side_t(side_d_t))
    u_div_scale (
    .clk_i, .rst_ni, .valid_i(valid_d_q), .num_i(scale_num_q), .den_i(ScaleDenW'(HbScale)),
    .side_i(side_d_q), .valid_o(valid_d_out), .quo_o(quo_d), .rem_o(), .side_o(side_d_out)
  );

  // Output stage.
  pix_t pix;

  always_comb begin
    pix.ovr    = side_d_out.ovr;
    pix.blink  = side_d_out.blink;
    pix.health = side_d_out.health;
    pix.level  = side_d_out.hb ? quo_d[7:0] : side_d_out.ramp_level;
  end

  slpg_pixel u_pixel (
    .clk_i, .rst_ni, .valid_i(valid_d_out), .pix_i(pix), .peak_i(peak_q), .grb_i(grb_q),
    .ovr_rgb_i(ovr_rgb_q), .done_o, .pixel_word_o, .level_o
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without a transaction accepted at the pipeline latency");

  a_ramp_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_b_q |-> (ramp_den_q != '0))
    else $error("ramp slope divisor is zero");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_b_out |-> (quo_pct_b < NumBW'(HbScale)))
    else $error("heartbeat phase out of range");

  a_lerp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_c_out |-> (quo_c <= LerpNumW'(side_c_out.dy_mag)))
    else $error("interpolation step exceeds segment rise");

endmodule

/* hw/rtl/slpg_div.sv */
// Pipelined restoring divider that resolves StepBits quotient bits per stage.
module slpg_div #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 16,
  parameter int unsigned StepBits = 4,
  parameter type side_t = logic
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  side_t           side_i,
  output logic            valid_o,
  output logic [NumW-1:0] quo_o,
  output logic [DenW-1:0] rem_o,
  output side_t           side_o
);

  localparam int unsigned Stages = (NumW + StepBits - 1) / StepBits;
  localparam int unsigned PadW = Stages * StepBits;

  logic [Stages-1:0] valid_q;
  logic [PadW-1:0]   work_q [Stages];
  logic [DenW-1:0]   rem_q  [Stages];
  logic [DenW-1:0]   den_q  [Stages];
  side_t             side_q [Stages];

  logic [Stages-1:0] valid_in;
  logic [PadW-1:0]   work_in [Stages];
  logic [DenW-1:0]   rem_in  [Stages];
  logic [DenW-1:0]   den_in  [Stages];
  side_t             side_in [Stages];

  logic [PadW-1:0]   work_d [Stages];
  logic [DenW-1:0]   rem_d  [Stages];

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign valid_in[g] = valid_i;
      assign work_in[g]  = PadW'(num_i);
      assign rem_in[g]   = '0;
      assign den_in[g]   = den_i;
      assign side_in[g]  = side_i;
    end else begin : g_next
      assign valid_in[g] = valid_q[g-1];
      assign work_in[g]  = work_q[g-1];
      assign rem_in[g]   = rem_q[g-1];
      assign den_in[g]   = den_q[g-1];
      assign side_in[g]  = side_q[g-1];
    end

    always_comb begin
      logic [DenW:0]   r;
      logic [PadW-1:0] w;
      r = {1'b0, rem_in[g]};
      w = work_in[g];
      for (int unsigned b = 0; b < StepBits; b++) begin
        r = {r[DenW-1:0], w[PadW-1]};
        w = {w[PadW-2:0], 1'b0};
        if (r >= {1'b0, den_in[g]}) begin
          r = r - {1'b0, den_in[g]};
          w[0] = 1'b1;
        end
      end
      rem_d[g]  = r[DenW-1:0];
      work_d[g] = w;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else begin
        valid_q[g] <= valid_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      work_q[g] <= work_d[g];
      rem_q[g]  <= rem_d[g];
      den_q[g]  <= den_in[g];
      side_q[g] <= side_in[g];
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign quo_o   = work_q[Stages-1][NumW-1:0];
  assign rem_o   = rem_q[Stages-1];
  assign side_o  = side_q[Stages-1];

endmodule

/* hw/rtl/slpg_pixel.sv */
// Output stage that forms the colour word and registers the result.
module slpg_pixel (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  slpg_pkg::pix_t pix_i,
  input  logic [7:0]    peak_i,
  input  logic          grb_i,
  input  logic [23:0]   ovr_rgb_i,
  output logic          done_o,
  output logic [23:0]   pixel_word_o,
  output logic [7:0]    level_o
);

  import slpg_pkg::*;

  logic        done_q;
  logic [23:0] word_q, word_d, rgb;
  logic [7:0]  level_q, level_d;

  always_comb begin
    rgb = '0;
    level_d = pix_i.level;
    if (pix_i.ovr) begin
      level_d = '0;
      rgb = pix_i.blink ? ovr_rgb_i : '0;
    end else begin
      unique case (pix_i.health)
        HealthOk:       rgb = {8'd0, pix_i.level, 8'd0};
        HealthWarn:     rgb = {pix_i.level, pix_i.level, 8'd0};
        HealthError:    rgb = {peak_i, 16'd0};
        HealthUpdating: rgb = {16'd0, pix_i.level};
        default:        rgb = '0;
      endcase
    end
    word_d = grb_i ? {rgb[15:8], rgb[23:16], rgb[7:0]} : rgb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    level_q <= level_d;
  end

  assign done_o       = done_q;
  assign pixel_word_o = word_q;
  assign level_o      = level_q;

endmodule
